// ===== hdl/camera_yaw_pitch_basis_unit_defines.svh =====
// Assertion macros for the camera yaw/pitch basis unit.
// Included by the checker module; relies on clk and rst_n in scope.
`ifndef CAMERA_YAW_PITCH_BASIS_UNIT_DEFINES_SVH
`define CAMERA_YAW_PITCH_BASIS_UNIT_DEFINES_SVH

// Checked only while the block is out of reset.
`define CYPB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define CYPB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/cypb_pkg.sv =====
// Shared types, constants and helper functions of the camera basis unit.
// No dependencies; used by cypb_cordic and camera_yaw_pitch_basis_unit.
package cypb_pkg;

  localparam int TRIG_ITERATIONS = 16;
  localparam int VEC_FRAC_BITS   = 14;

  localparam int NUM_ITER = (TRIG_ITERATIONS < 24) ? TRIG_ITERATIONS : 24;
  localparam int ITER_W   = (NUM_ITER > 1) ? $clog2(NUM_ITER) : 1;
  localparam int VEC_W    = VEC_FRAC_BITS + 3;
  localparam int ZW       = 33;

  // CORDIC gain-compensated start value, rounded to the vector scale.
  localparam int CORDIC_X0 =
    (652032874 + (1 << (29 - VEC_FRAC_BITS))) >> (30 - VEC_FRAC_BITS);

  localparam int FULL_TURN    = 46080;
  localparam int QUARTER_TURN = 11520;
  localparam int HALF_TURN    = 2 * QUARTER_TURN;
  localparam int THREE_QUART  = 3 * QUARTER_TURN;
  localparam int RAD_SCALE    = 37480660;
  localparam int YAW_BIAS     = FULL_TURN * 256;
  localparam int RED_STEPS    = 9;

  localparam int MA_W   = 27;
  localparam int MB_W   = (VEC_W > 17) ? VEC_W : 17;
  localparam int PROD_W = MA_W + MB_W;
  localparam int MUL_HALF = 1 << (VEC_FRAC_BITS - 1);

  localparam int OUT_RS   = (VEC_FRAC_BITS >= 14) ? (VEC_FRAC_BITS - 14) : 0;
  localparam int OUT_LS   = (VEC_FRAC_BITS < 14) ? (14 - VEC_FRAC_BITS) : 0;
  localparam int OUT_HALF = (OUT_RS > 0) ? (1 << (OUT_RS - 1)) : 0;

  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] CFG_SENS      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PITCH_MAX = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_PITCH_MIN = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_POS_X     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_POS_Y     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_POS_Z     = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MULX,
    ST_MULY,
    ST_RED,
    ST_ZY,
    ST_CY,
    ST_ZP,
    ST_CP,
    ST_PROD,
    ST_FIN
  } state_t;

  function automatic logic signed [ZW-1:0] atan_val(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:  v = 33'sd843314856;
      5'd1:  v = 33'sd497837829;
      5'd2:  v = 33'sd263043836;
      5'd3:  v = 33'sd133525158;
      5'd4:  v = 33'sd67021686;
      5'd5:  v = 33'sd33543515;
      5'd6:  v = 33'sd16775850;
      5'd7:  v = 33'sd8388437;
      5'd8:  v = 33'sd4194282;
      5'd9:  v = 33'sd2097149;
      5'd10: v = 33'sd1048575;
      5'd11: v = 33'sd524287;
      5'd12: v = 33'sd262143;
      5'd13: v = 33'sd131071;
      5'd14: v = 33'sd65535;
      5'd15: v = 33'sd32767;
      5'd16: v = 33'sd16383;
      5'd17: v = 33'sd8191;
      5'd18: v = 33'sd4095;
      5'd19: v = 33'sd2047;
      5'd20: v = 33'sd1023;
      5'd21: v = 33'sd511;
      5'd22: v = 33'sd255;
      5'd23: v = 33'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Brings a vector value to 14 fractional bits and saturates to 16 bits.
  function automatic logic signed [15:0] to_out(input logic signed [39:0] v);
    logic signed [47:0] r;
    logic signed [15:0] o;
    r = ((48'(v) + OUT_HALF) >>> OUT_RS) <<< OUT_LS;
    if (r > 48'sd32767) begin
      o = 16'sh7fff;
    end else if (r < -48'sd32768) begin
      o = 16'sh8000;
    end else begin
      o = 16'(r);
    end
    return o;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] t);
    logic signed [31:0] o;
    if (t > 34'sd2147483647) begin
      o = 32'sh7fffffff;
    end else if (t < -34'sd2147483648) begin
      o = 32'sh80000000;
    end else begin
      o = 32'(t);
    end
    return o;
  endfunction

endpackage

// ===== hdl/camera_yaw_pitch_basis_unit.sv =====
// Camera yaw/pitch basis unit: turns cursor offset beats into camera vectors.
// Depends on cypb_pkg and cypb_cordic.
//
// Usage:
//   Input channel (in_valid / in_stall): one beat carries a cursor offset pair.
//   The block stalls the input for the whole time it works on a beat and
//   releases it once the result has moved into the output register.
//   Output channel (out_valid / out_stall): one beat carries the direction,
//   right and up vectors and the target point. The output register lets the
//   next input beat be taken while a finished result waits for the receiver.
//   Configuration: cfg_we writes cfg_wdata into the register picked by
//   cfg_idx (sensitivity, pitch limits, position); write only while idle.
// Sequence:
//   After the accept step one beat passes through offset scaling, the yaw wrap
//   steps, two CORDIC runs (yaw, then pitch), the products of their sines and
//   cosines and a final step. The single shared multiplier and the single CORDIC
//   engine serve one beat at a time, so a new beat waits until the last is done.
// Reset: synchronous, active low. Configuration registers return to defaults,
//   yaw to 270 degrees, pitch to zero, and no result is pending.
// Stall: a stalled result holds its value; if a new result is ready while the
//   old one is still stalled, the block waits in its final step.
module camera_yaw_pitch_basis_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [15:0]                   in_cursor_dx,
  input  logic signed [15:0]                   in_cursor_dy,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [15:0]                   out_dir_x,
  output logic signed [15:0]                   out_dir_y,
  output logic signed [15:0]                   out_dir_z,
  output logic signed [15:0]                   out_right_x,
  output logic signed [15:0]                   out_right_z,
  output logic signed [15:0]                   out_up_x,
  output logic signed [15:0]                   out_up_y,
  output logic signed [15:0]                   out_up_z,
  output logic signed [31:0]                   out_target_x,
  output logic signed [31:0]                   out_target_y,
  output logic signed [31:0]                   out_target_z,
  input  logic                                 cfg_we,
  input  logic [cypb_pkg::CFG_ADDR_W-1:0]      cfg_idx,
  input  logic [31:0]                          cfg_wdata
);

  // Configuration registers.
  logic [15:0]        sens_r;
  logic [13:0]        pmax_r;
  logic signed [14:0] pmin_r;
  logic signed [31:0] posx_r, posy_r, posz_r;

  // Camera state.
  logic [15:0]        yaw_r;
  logic signed [14:0] pitch_r;

  // Sequencer.
  cypb_pkg::state_t state_r, state_nxt;
  logic [3:0]       k_r;
  logic [1:0]       pk_r;

  // Working registers.
  logic signed [15:0] dx_r, dy_r;
  logic [25:0]        acc_r;
  logic signed [cypb_pkg::VEC_W-1:0] cy_r, sy_r, cp_r, sp_r;
  logic signed [15:0] v0_r, v2_r, v5_r, v7_r;

  // Output register.
  logic               out_valid_r;
  logic signed [15:0] dir_x_r, dir_y_r, dir_z_r, right_x_r, right_z_r;
  logic signed [15:0] up_x_r, up_y_r, up_z_r;
  logic signed [31:0] tgt_x_r, tgt_y_r, tgt_z_r;

  // Shared multiplier.
  logic signed [cypb_pkg::MA_W-1:0]   mul_a;
  logic signed [cypb_pkg::MB_W-1:0]   mul_b;
  logic signed [cypb_pkg::PROD_W-1:0] prod;
  logic signed [23:0]                 delta;
  logic signed [39:0]                 mv, mv_sel;
  logic signed [15:0]                 mv_out;

  // Angle preparation and CORDIC hookup.
  logic [15:0]        pitch_wrap, ang_src;
  logic [1:0]         quad;
  logic [13:0]        rem;
  logic signed [cypb_pkg::ZW-1:0]    z0;
  logic               cordic_start, cordic_done;
  logic signed [cypb_pkg::VEC_W-1:0] c_cos, c_sin;

  // Pitch update and yaw wrap.
  logic signed [25:0] p_sum;
  logic signed [14:0] p_new;
  logic [25:0]        acc_init, turn_k;

  // Final assembly.
  logic               out_load;
  logic signed [15:0] f_dir_y, f_right_x, f_right_z, f_up_y;

  assign in_stall  = (state_r != cypb_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------------
  // Configuration port.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r <= 16'd410;
      pmax_r <= 14'd11392;
      pmin_r <= -15'sd11392;
      posx_r <= '0;
      posy_r <= '0;
      posz_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        cypb_pkg::CFG_SENS:      sens_r <= cfg_wdata[15:0];
        cypb_pkg::CFG_PITCH_MAX: pmax_r <= cfg_wdata[13:0];
        cypb_pkg::CFG_PITCH_MIN: pmin_r <= cfg_wdata[14:0];
        cypb_pkg::CFG_POS_X:     posx_r <= cfg_wdata;
        cypb_pkg::CFG_POS_Y:     posy_r <= cfg_wdata;
        cypb_pkg::CFG_POS_Z:     posz_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Shared multiplier: offset scaling, radian conversion and the products
  // of yaw and pitch sines and cosines all take turns on it.
  // ---------------------------------------------------------------------
  always_comb begin
    unique case (state_r)
      cypb_pkg::ST_MULX: begin
        mul_a = cypb_pkg::MA_W'(dx_r);
        mul_b = cypb_pkg::MB_W'(signed'({1'b0, sens_r}));
      end
      cypb_pkg::ST_MULY: begin
        mul_a = cypb_pkg::MA_W'(dy_r);
        mul_b = cypb_pkg::MB_W'(signed'({1'b0, sens_r}));
      end
      cypb_pkg::ST_ZY, cypb_pkg::ST_ZP: begin
        mul_a = cypb_pkg::MA_W'(cypb_pkg::RAD_SCALE);
        mul_b = cypb_pkg::MB_W'(signed'({1'b0, rem}));
      end
      cypb_pkg::ST_PROD: begin
        unique case (pk_r)
          2'd0: begin
            mul_a = cypb_pkg::MA_W'(cy_r);
            mul_b = cypb_pkg::MB_W'(cp_r);
          end
          2'd1: begin
            mul_a = cypb_pkg::MA_W'(sy_r);
            mul_b = cypb_pkg::MB_W'(cp_r);
          end
          2'd2: begin
            mul_a = cypb_pkg::MA_W'(cy_r);
            mul_b = cypb_pkg::MB_W'(sp_r);
          end
          2'd3: begin
            mul_a = cypb_pkg::MA_W'(sy_r);
            mul_b = cypb_pkg::MB_W'(sp_r);
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod  = cypb_pkg::PROD_W'(mul_a) * cypb_pkg::PROD_W'(mul_b);
  assign delta = 24'(prod >>> 9);

  // Rounded vector product; the up vector terms are negated.
  assign mv     = 40'((prod + cypb_pkg::MUL_HALF) >>> cypb_pkg::VEC_FRAC_BITS);
  assign mv_sel = pk_r[1] ? -mv : mv;
  assign mv_out = cypb_pkg::to_out(mv_sel);

  // ---------------------------------------------------------------------
  // Pitch clamp (upper limit first, so the lower limit wins) and yaw wrap.
  // Yaw is biased by 256 turns to stay positive, then reduced by
  // subtracting 256, 128, ... 1 turns, one compare per cycle.
  // ---------------------------------------------------------------------
  assign p_sum = 26'(pitch_r) + 26'(delta);

  always_comb begin
    logic signed [25:0] p;
    p = p_sum;
    if (p > signed'({12'd0, pmax_r})) begin
      p = signed'({12'd0, pmax_r});
    end
    if (p < 26'(pmin_r)) begin
      p = 26'(pmin_r);
    end
    p_new = 15'(p);
  end

  assign acc_init = 26'(27'(yaw_r) + 27'(delta) + 27'(cypb_pkg::YAW_BIAS));
  assign turn_k   = 26'(cypb_pkg::FULL_TURN) << k_r;

  // ---------------------------------------------------------------------
  // Angle to first-quadrant remainder and CORDIC start angle.
  // ---------------------------------------------------------------------
  assign pitch_wrap = pitch_r[14] ? 16'(32'(pitch_r) + cypb_pkg::FULL_TURN)
                                  : 16'(pitch_r);
  assign ang_src    = (state_r == cypb_pkg::ST_ZY) ? yaw_r : pitch_wrap;

  always_comb begin
    priority if (ang_src >= 16'(cypb_pkg::THREE_QUART)) begin
      quad = 2'd3;
      rem  = 14'(ang_src - 16'(cypb_pkg::THREE_QUART));
    end else if (ang_src >= 16'(cypb_pkg::HALF_TURN)) begin
      quad = 2'd2;
      rem  = 14'(ang_src - 16'(cypb_pkg::HALF_TURN));
    end else if (ang_src >= 16'(cypb_pkg::QUARTER_TURN)) begin
      quad = 2'd1;
      rem  = 14'(ang_src - 16'(cypb_pkg::QUARTER_TURN));
    end else begin
      quad = 2'd0;
      rem  = 14'(ang_src);
    end
  end

  assign z0           = cypb_pkg::ZW'(prod >>> 8);
  assign cordic_start = (state_r == cypb_pkg::ST_ZY) || (state_r == cypb_pkg::ST_ZP);

  cypb_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .z0    (z0),
    .quad  (quad),
    .done  (cordic_done),
    .cos_o (c_cos),
    .sin_o (c_sin)
  );

  // ---------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------
  assign out_load = (state_r == cypb_pkg::ST_FIN) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cypb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cypb_pkg::ST_IDLE: if (in_valid) state_nxt = cypb_pkg::ST_MULX;
      cypb_pkg::ST_MULX: state_nxt = cypb_pkg::ST_MULY;
      cypb_pkg::ST_MULY: state_nxt = cypb_pkg::ST_RED;
      cypb_pkg::ST_RED:  if (k_r == '0) state_nxt = cypb_pkg::ST_ZY;
      cypb_pkg::ST_ZY:   state_nxt = cypb_pkg::ST_CY;
      cypb_pkg::ST_CY:   if (cordic_done) state_nxt = cypb_pkg::ST_ZP;
      cypb_pkg::ST_ZP:   state_nxt = cypb_pkg::ST_CP;
      cypb_pkg::ST_CP:   if (cordic_done) state_nxt = cypb_pkg::ST_PROD;
      cypb_pkg::ST_PROD: if (pk_r == 2'd3) state_nxt = cypb_pkg::ST_FIN;
      cypb_pkg::ST_FIN:  if (out_load) state_nxt = cypb_pkg::ST_IDLE;
    endcase
  end

  // Camera state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_r   <= 16'd34560;
      pitch_r <= '0;
    end else begin
      if (state_r == cypb_pkg::ST_MULY) begin
        pitch_r <= p_new;
      end
      if ((state_r == cypb_pkg::ST_RED) && (k_r == '0)) begin
        yaw_r <= (acc_r >= turn_k) ? 16'(acc_r - turn_k) : 16'(acc_r);
      end
    end
  end

  // Working registers; pure payload, no reset needed.
  always_ff @(posedge clk) begin
    unique case (state_r)
      cypb_pkg::ST_IDLE: begin
        dx_r <= in_cursor_dx;
        dy_r <= in_cursor_dy;
        pk_r <= '0;
      end
      cypb_pkg::ST_MULX: acc_r <= acc_init;
      cypb_pkg::ST_MULY: k_r <= 4'(cypb_pkg::RED_STEPS - 1);
      cypb_pkg::ST_RED: begin
        if (acc_r >= turn_k) begin
          acc_r <= acc_r - turn_k;
        end
        k_r <= k_r - 1'b1;
      end
      cypb_pkg::ST_CY: begin
        if (cordic_done) begin
          cy_r <= c_cos;
          sy_r <= c_sin;
        end
      end
      cypb_pkg::ST_CP: begin
        if (cordic_done) begin
          cp_r <= c_cos;
          sp_r <= c_sin;
        end
      end
      cypb_pkg::ST_PROD: begin
        unique case (pk_r)
          2'd0: v0_r <= mv_out;
          2'd1: v2_r <= mv_out;
          2'd2: v5_r <= mv_out;
          2'd3: v7_r <= mv_out;
        endcase
        pk_r <= pk_r + 1'b1;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Final assembly into the output register.
  // ---------------------------------------------------------------------
  assign f_dir_y   = cypb_pkg::to_out(40'(sp_r));
  assign f_right_x = cypb_pkg::to_out(-40'(sy_r));
  assign f_right_z = cypb_pkg::to_out(40'(cy_r));
  assign f_up_y    = cypb_pkg::to_out(40'(cp_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      dir_x_r   <= v0_r;
      dir_y_r   <= f_dir_y;
      dir_z_r   <= v2_r;
      right_x_r <= f_right_x;
      right_z_r <= f_right_z;
      up_x_r    <= v5_r;
      up_y_r    <= f_up_y;
      up_z_r    <= v7_r;
      tgt_x_r   <= cypb_pkg::sat32(34'(posx_r) + 34'(v0_r));
      tgt_y_r   <= cypb_pkg::sat32(34'(posy_r) + 34'(f_dir_y));
      tgt_z_r   <= cypb_pkg::sat32(34'(posz_r) + 34'(v2_r));
    end
  end

  assign out_dir_x    = dir_x_r;
  assign out_dir_y    = dir_y_r;
  assign out_dir_z    = dir_z_r;
  assign out_right_x  = right_x_r;
  assign out_right_z  = right_z_r;
  assign out_up_x     = up_x_r;
  assign out_up_y     = up_y_r;
  assign out_up_z     = up_z_r;
  assign out_target_x = tgt_x_r;
  assign out_target_y = tgt_y_r;
  assign out_target_z = tgt_z_r;

endmodule

// ===== hdl/cypb_cordic.sv =====
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Depends on cypb_pkg for widths, iteration count and the arctangent table.
module cypb_cordic (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [cypb_pkg::ZW-1:0]      z0,
  input  logic [1:0]                          quad,
  output logic                                done,
  output logic signed [cypb_pkg::VEC_W-1:0]   cos_o,
  output logic signed [cypb_pkg::VEC_W-1:0]   sin_o
);

  logic signed [cypb_pkg::VEC_W-1:0] x_r, y_r, x_nxt, y_nxt, dx, dy;
  logic signed [cypb_pkg::ZW-1:0]    z_r, z_nxt, ang;
  logic [cypb_pkg::ITER_W-1:0]       it_r;
  logic [1:0]                        quad_r;
  logic                              busy_r, done_r, last;

  assign dx   = y_r >>> it_r;
  assign dy   = x_r >>> it_r;
  assign ang  = cypb_pkg::atan_val(5'(it_r));
  assign last = (it_r == cypb_pkg::ITER_W'(cypb_pkg::NUM_ITER - 1));

  always_comb begin
    if (z_r >= 0) begin
      x_nxt = x_r - dx;
      y_nxt = y_r + dy;
      z_nxt = z_r - ang;
    end else begin
      x_nxt = x_r + dx;
      y_nxt = y_r - dy;
      z_nxt = z_r + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
        it_r   <= '0;
      end else if (busy_r) begin
        if (last) begin
          busy_r <= 1'b0;
        end
        it_r <= it_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= cypb_pkg::VEC_W'(cypb_pkg::CORDIC_X0);
      y_r    <= '0;
      z_r    <= z0;
      quad_r <= quad;
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  // Fold the first-quadrant result back to the full circle.
  always_comb begin
    unique case (quad_r)
      2'd0: begin
        cos_o = x_r;
        sin_o = y_r;
      end
      2'd1: begin
        cos_o = -y_r;
        sin_o = x_r;
      end
      2'd2: begin
        cos_o = -x_r;
        sin_o = -y_r;
      end
      2'd3: begin
        cos_o = y_r;
        sin_o = -x_r;
      end
    endcase
  end

  assign done = done_r;

endmodule

// ===== hdl/cypb_checker.sv =====
// Port-level checker for the camera yaw/pitch basis unit, bound to the top.
// Depends on camera_yaw_pitch_basis_unit_defines.svh for the assertion macros.
`include "camera_yaw_pitch_basis_unit_defines.svh"

module cypb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_dir_x,
  input logic signed [31:0] out_target_x
);

  // After reset nothing is pending and the input is open.
  `CYPB_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid && !in_stall, "not idle after reset")

  // An accepted beat closes the input while the block works on it.
  `CYPB_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "input open after accept")

  `CYPB_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "stalled result dropped")

  `CYPB_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_dir_x) && $stable(out_target_x), "stalled result changed")

endmodule

bind camera_yaw_pitch_basis_unit cypb_checker u_cypb_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_dir_x    (out_dir_x),
  .out_target_x (out_target_x)
);
